// ----- rtl/kmsd_pkg.sv -----
package kmsd_pkg;

    localparam int unsigned PIN_W     = 5;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned TMR_W     = 16;
    localparam int unsigned LINES_DEF = 5;
    localparam int unsigned S_DATA_W  = 8;
    localparam int unsigned M_DATA_W  = 16;

    localparam logic [IDX_W-1:0] NONE_IDX   = 4'd8;
    localparam logic [TMR_W-1:0] RELOAD_RST = 16'd20;

    typedef struct packed {
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
    } scan_t;

    typedef struct packed {
        logic             up_pending;
        logic             down_pending;
        logic             pressed;
        logic [IDX_W-1:0] held_row;
        logic [IDX_W-1:0] held_col;
    } result_t;

    function automatic logic [PIN_W-1:0] line_mask(input int unsigned lines);
        logic [PIN_W-1:0] m;
        for (int unsigned i = 0; i < PIN_W; i++) begin
            m[i] = (i < lines);
        end
        return m;
    endfunction

    // index of the lowest set line, NONE_IDX when no line is set
    function automatic logic [IDX_W-1:0] lowest_line(input logic [PIN_W-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = NONE_IDX;
        for (int i = PIN_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/kmsd_scan.sv -----
module kmsd_scan #(
    parameter int unsigned LINES = kmsd_pkg::LINES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [kmsd_pkg::PIN_W-1:0]   pin_sample,
    output kmsd_pkg::scan_t              scan
);

    localparam logic [kmsd_pkg::PIN_W-1:0] MASK = kmsd_pkg::line_mask(LINES);
    localparam int unsigned IDX_CAP = (LINES < kmsd_pkg::PIN_W) ? LINES : kmsd_pkg::PIN_W;

    logic                        scan_phase_reg;
    logic [kmsd_pkg::IDX_W-1:0]  cur_col_reg, cur_col_next;
    logic [kmsd_pkg::IDX_W-1:0]  cur_row_reg, cur_row_next;

    always_comb begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (!scan_phase_reg) begin
            cur_col_next = kmsd_pkg::lowest_line(~pin_sample & MASK);
        end else begin
            cur_row_next = kmsd_pkg::lowest_line(pin_sample & MASK);
        end
    end

    assign scan.col = cur_col_next;
    assign scan.row = cur_row_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_phase_reg <= 1'b0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
        end else if (step) begin
            scan_phase_reg <= ~scan_phase_reg;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_toggles: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> scan_phase_reg != $past(scan_phase_reg))
        else $error("scan phase did not alternate");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg < kmsd_pkg::IDX_W'(IDX_CAP)) || (cur_col_reg == kmsd_pkg::NONE_IDX))
        else $error("column index beyond matrix");
`endif

endmodule

// ----- rtl/kmsd_fsm.sv -----
module kmsd_fsm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         time_tick,
    input  logic                         ack_down,
    input  logic                         ack_up,
    input  logic [kmsd_pkg::TMR_W-1:0]   debounce_reload,
    input  kmsd_pkg::scan_t              scan,
    output kmsd_pkg::result_t            result
);

    typedef enum logic [1:0] {
        KS_IDLE     = 2'd0,
        KS_DOWN     = 2'd1,
        KS_DEBOUNCE = 2'd2
    } key_state_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_UP   = 2'd1,
        EV_DOWN = 2'd2
    } event_t;

    key_state_t                  key_state_reg, key_state_next;
    event_t                      pending_reg, pending_next;
    logic [kmsd_pkg::TMR_W-1:0]  timer_reg, timer_next;
    logic [kmsd_pkg::IDX_W-1:0]  latched_col_reg, latched_col_next;
    logic [kmsd_pkg::IDX_W-1:0]  latched_row_reg, latched_row_next;
    logic                        col_hit, row_hit;

    assign col_hit = (scan.col != kmsd_pkg::NONE_IDX);
    assign row_hit = (scan.row != kmsd_pkg::NONE_IDX);

    always_comb begin
        key_state_next   = key_state_reg;
        pending_next     = pending_reg;
        timer_next       = timer_reg;
        latched_col_next = latched_col_reg;
        latched_row_next = latched_row_reg;

        if (ack_down && pending_reg == EV_DOWN) begin
            pending_next = EV_NONE;
        end
        if (ack_up && pending_reg == EV_UP) begin
            pending_next = EV_NONE;
        end
        if (time_tick && timer_reg != '0) begin
            timer_next = timer_reg - 1'b1;
        end

        if (col_hit && row_hit) begin
            if (key_state_reg == KS_IDLE) begin
                latched_col_next = scan.col;
                latched_row_next = scan.row;
                key_state_next   = KS_DOWN;
                pending_next     = EV_DOWN;
            end else if (key_state_reg != KS_DOWN) begin
                timer_next = debounce_reload;
            end
        end else if (col_hit) begin
            if (key_state_reg != KS_IDLE && key_state_reg != KS_DOWN) begin
                timer_next = debounce_reload;
            end
        end else begin
            if (key_state_reg == KS_DOWN) begin
                timer_next     = debounce_reload;
                key_state_next = KS_DEBOUNCE;
                pending_next   = EV_UP;
            end
            if (key_state_next != KS_IDLE && key_state_next != KS_DOWN
                    && timer_next == '0) begin
                key_state_next = KS_IDLE;
            end
        end
    end

    assign result.held_col     = latched_col_next;
    assign result.held_row     = latched_row_next;
    assign result.pressed      = (key_state_next == KS_DOWN);
    assign result.down_pending = (pending_next == EV_DOWN);
    assign result.up_pending   = (pending_next == EV_UP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_state_reg   <= KS_IDLE;
            pending_reg     <= EV_NONE;
            timer_reg       <= '0;
            latched_col_reg <= '0;
            latched_row_reg <= '0;
        end else if (step) begin
            key_state_reg   <= key_state_next;
            pending_reg     <= pending_next;
            timer_reg       <= timer_next;
            latched_col_reg <= latched_col_next;
            latched_row_reg <= latched_row_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (key_state_reg == KS_IDLE) |-> (timer_reg == '0))
        else $error("timer running while idle");

    a_down_no_up_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (key_state_reg == KS_DOWN) |-> (pending_reg != EV_UP))
        else $error("up event pending while key down");
`endif

endmodule

// ----- rtl/key_matrix_scan_debounce.sv -----
// Path: an input beat is taken into the input register, its result then into the
// result register, which presents it on m_tvalid; m_tready stalls hold both.
// Throughput: one beat per cycle unless m_tready stalls the output.
// The scan step is one encode and one state update.
// Reset: aresetn synchronous, active low; clears scan and key state, pending
// events, timer, and sets the debounce reload to 20 ticks.
module key_matrix_scan_debounce #(
    parameter int unsigned LINES = kmsd_pkg::LINES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kmsd_pkg::TMR_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pin_sample[4:0], time_tick[5], ack_down[6], ack_up[7]
    input  logic [kmsd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // held_col[3:0], held_row[7:4], pressed[8], down_pending[9], up_pending[10]
    output logic [kmsd_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int unsigned RES_W = $bits(kmsd_pkg::result_t);

    logic [kmsd_pkg::TMR_W-1:0]     reload_reg;
    logic                           in_vld_reg;
    logic [kmsd_pkg::S_DATA_W-1:0]  in_data_reg;
    logic                           out_vld_reg;
    kmsd_pkg::result_t              out_res_reg;
    logic                           adv;
    logic                           step;
    kmsd_pkg::scan_t                scan;
    kmsd_pkg::result_t              result;

    assign adv      = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && adv;
    assign s_tready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= kmsd_pkg::RELOAD_RST;
        end else if (cfg_wr_en) begin
            reload_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (adv) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (step) begin
            out_res_reg <= result;
        end
    end

    kmsd_scan #(
        .LINES (LINES)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .pin_sample (in_data_reg[kmsd_pkg::PIN_W-1:0]),
        .scan       (scan)
    );

    kmsd_fsm u_fsm (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .time_tick       (in_data_reg[5]),
        .ack_down        (in_data_reg[6]),
        .ack_up          (in_data_reg[7]),
        .debounce_reload (reload_reg),
        .scan            (scan),
        .result          (result)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(kmsd_pkg::M_DATA_W - RES_W){1'b0}}, out_res_reg};

endmodule

// ----- tb/key_matrix_scan_debounce_tb.sv -----
`timescale 1ns / 100ps

module key_matrix_scan_debounce_tb;

    localparam int unsigned LINES = kmsd_pkg::LINES_DEF;
    localparam logic [kmsd_pkg::PIN_W-1:0] LINE_MASK = kmsd_pkg::PIN_W'((1 << LINES) - 1);

    typedef enum logic [1:0] {
        KEY_IDLE     = 2'd0,
        KEY_DOWN     = 2'd1,
        KEY_DEBOUNCE = 2'd2
    } key_state_t;

    typedef enum logic [1:0] {
        EVT_NONE = 2'd0,
        EVT_UP   = 2'd1,
        EVT_DOWN = 2'd2
    } key_event_t;

    typedef struct packed {
        logic                       ack_up;
        logic                       ack_down;
        logic                       time_tick;
        logic [kmsd_pkg::PIN_W-1:0] pin_sample;
    } scan_beat_t;

    class keypad_scoreboard;
        kmsd_pkg::result_t          report_q[$];
        int                         errors;
        logic [kmsd_pkg::TMR_W-1:0] reload;
        logic                       col_phase_done;
        logic [kmsd_pkg::IDX_W-1:0] col_idx;
        logic [kmsd_pkg::IDX_W-1:0] row_idx;
        logic [kmsd_pkg::IDX_W-1:0] held_col;
        logic [kmsd_pkg::IDX_W-1:0] held_row;
        key_state_t                 kstate;
        key_event_t                 evt;
        logic [kmsd_pkg::TMR_W-1:0] timer;

        function new();
            errors         = 0;
            reload         = kmsd_pkg::RELOAD_RST;
            col_phase_done = 1'b0;
            col_idx        = '0;
            row_idx        = '0;
            held_col       = '0;
            held_row       = '0;
            kstate         = KEY_IDLE;
            evt            = EVT_NONE;
            timer          = '0;
        endfunction

        function void set_reload(logic [kmsd_pkg::TMR_W-1:0] v);
            reload = v;
        endfunction

        function logic [kmsd_pkg::IDX_W-1:0] first_set(logic [kmsd_pkg::PIN_W-1:0] v);
            for (int i = 0; i < kmsd_pkg::PIN_W; i++) begin
                if (v[i]) begin
                    return kmsd_pkg::IDX_W'(i);
                end
            end
            return kmsd_pkg::NONE_IDX;
        endfunction

        function void take_scan(scan_beat_t b);
            kmsd_pkg::result_t r;
            logic              col_on;
            logic              row_on;
            if (b.ack_down && evt == EVT_DOWN) evt = EVT_NONE;
            if (b.ack_up && evt == EVT_UP) evt = EVT_NONE;
            if (b.time_tick && timer != 0) timer = timer - 1'b1;

            if (!col_phase_done) begin
                col_idx = first_set(~b.pin_sample & LINE_MASK);
            end else begin
                row_idx = first_set(b.pin_sample & LINE_MASK);
            end
            col_phase_done = ~col_phase_done;

            col_on = (col_idx != kmsd_pkg::NONE_IDX);
            row_on = (row_idx != kmsd_pkg::NONE_IDX);
            if (col_on && row_on) begin
                if (kstate == KEY_IDLE) begin
                    held_col = col_idx;
                    held_row = row_idx;
                    kstate   = KEY_DOWN;
                    evt      = EVT_DOWN;
                end else if (kstate != KEY_DOWN) begin
                    timer = reload;
                end
            end else if (col_on) begin
                if (kstate == KEY_DEBOUNCE) timer = reload;
            end else begin
                if (kstate == KEY_DOWN) begin
                    timer  = reload;
                    kstate = KEY_DEBOUNCE;
                    evt    = EVT_UP;
                end
                if (kstate == KEY_DEBOUNCE && timer == 0) kstate = KEY_IDLE;
            end

            r.held_col     = held_col;
            r.held_row     = held_row;
            r.pressed      = (kstate == KEY_DOWN);
            r.down_pending = (evt == EVT_DOWN);
            r.up_pending   = (evt == EVT_UP);
            report_q.push_back(r);
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= 10) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d", $realtime, what,
                         want, got);
            end
        endfunction

        function void check_report(logic [kmsd_pkg::M_DATA_W-1:0] d);
            kmsd_pkg::result_t got;
            kmsd_pkg::result_t want;
            got = kmsd_pkg::result_t'(d[$bits(kmsd_pkg::result_t)-1:0]);
            if (report_q.size() == 0) begin
                flag("unexpected result beat", 0, d);
                return;
            end
            want = report_q.pop_front();
            if (got.held_col !== want.held_col) flag("held_col", want.held_col, got.held_col);
            if (got.held_row !== want.held_row) flag("held_row", want.held_row, got.held_row);
            if (got.pressed !== want.pressed) flag("pressed", want.pressed, got.pressed);
            if (got.down_pending !== want.down_pending) begin
                flag("down_pending", want.down_pending, got.down_pending);
            end
            if (got.up_pending !== want.up_pending) begin
                flag("up_pending", want.up_pending, got.up_pending);
            end
            if (d[kmsd_pkg::M_DATA_W-1:$bits(kmsd_pkg::result_t)] !== '0) begin
                flag("tdata padding", 0, d[kmsd_pkg::M_DATA_W-1:$bits(kmsd_pkg::result_t)]);
            end
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void close();
            if (report_q.size() != 0) flag("results never seen", 0, report_q.size());
            errors += report_q.size() - (report_q.size() != 0);
        endfunction
    endclass

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [kmsd_pkg::TMR_W-1:0]      cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [kmsd_pkg::S_DATA_W-1:0]   s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [kmsd_pkg::M_DATA_W-1:0]   m_tdata;

    keypad_scoreboard sb = new();
    int unsigned      beats_sent = 0;
    int unsigned      cur_reload = kmsd_pkg::RELOAD_RST;
    bit               quiet      = 1'b0;
    int               stall_left = 0;

    key_matrix_scan_debounce #(
        .LINES(LINES)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_scan(scan_beat_t'(s_tdata));
            if (m_tvalid && m_tready) sb.check_report(m_tdata);
        end
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sink stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input scan_beat_t b);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    function automatic scan_beat_t mk(logic [kmsd_pkg::PIN_W-1:0] pins, bit tick, bit ackd,
                                      bit acku);
        scan_beat_t b;
        b.pin_sample = pins;
        b.time_tick  = tick;
        b.ack_down   = ackd;
        b.ack_up     = acku;
        return b;
    endfunction

    // key (c, r) held: pins below the key's line stay inactive, above it are random
    function automatic scan_beat_t press_beat(int c, int r);
        logic [kmsd_pkg::PIN_W-1:0] above;
        logic [kmsd_pkg::PIN_W-1:0] pins;
        if (beats_sent[0] == 1'b0) begin
            above = kmsd_pkg::PIN_W'(~((2 << c) - 1));
            pins  = kmsd_pkg::PIN_W'(~(1 << c)) & ~(kmsd_pkg::PIN_W'($urandom) & above);
        end else begin
            above = kmsd_pkg::PIN_W'(~((2 << r) - 1));
            pins  = kmsd_pkg::PIN_W'(1 << r) | (kmsd_pkg::PIN_W'($urandom) & above);
        end
        return mk(pins, $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0);
    endfunction

    function automatic scan_beat_t release_beat();
        logic [kmsd_pkg::PIN_W-1:0] pins;
        pins = (beats_sent[0] == 1'b0) ? LINE_MASK : kmsd_pkg::PIN_W'($urandom);
        return mk(pins, $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0);
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned target;
        int          c;
        int          r;
        int          hold;
        int          rel;
        target = beats_sent + n;
        while (beats_sent < target) begin
            quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) != 0) begin
                c    = $urandom_range(0, LINES - 1);
                r    = $urandom_range(0, LINES - 1);
                hold = $urandom_range(1, 8);
                rel  = $urandom_range(1, (cur_reload < 40) ? cur_reload + 8 : 16);
                repeat (hold) send_beat(press_beat(c, r));
                repeat (rel) send_beat(release_beat());
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_beat(scan_beat_t'(kmsd_pkg::S_DATA_W'($urandom)));
                end
            end
        end
        quiet = 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_reload(input logic [kmsd_pkg::TMR_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_reload(v);
        cur_reload = v;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reload at reset value; first column latches with the stale row 0
        send_beat(mk(5'b01111, 0, 0, 1));
        send_beat(mk(5'b00000, 1, 0, 0));
        send_beat(mk(5'b11111, 0, 0, 1));   // release: up overwrites down
        send_beat(mk(5'b11111, 0, 1, 0));   // down ack leaves up alone
        send_beat(mk(5'b11110, 1, 0, 0));   // activity during debounce reloads
        send_beat(mk(5'b00001, 0, 0, 1));
        send_beat(mk(5'b01111, 1, 1, 0));
        send_beat(mk(5'b10000, 0, 0, 0));
        run_random(200);
        settle();

        // zero reload: down -> debounce -> idle in one step
        load_reload(16'd0);
        send_beat(mk(5'b11110, 0, 0, 0));
        send_beat(mk(5'b00010, 0, 0, 0));
        send_beat(mk(5'b11111, 0, 0, 0));
        send_beat(mk(5'b00100, 0, 0, 0));
        send_beat(mk(5'b11011, 0, 0, 0));
        send_beat(mk(5'b01000, 0, 0, 0));
        send_beat(mk(5'b11111, 1, 0, 0));
        run_random(150);
        settle();

        load_reload(16'd1);
        run_random(150);
        settle();

        load_reload(kmsd_pkg::TMR_W'($urandom_range(2, 40)));
        run_random(200);
        settle();

        load_reload(16'hFFFF);
        send_beat(mk(5'b11111, 1, 1, 1));
        send_beat(mk(5'b00000, 0, 0, 0));
        send_beat(mk(5'b00000, 1, 1, 1));
        send_beat(mk(5'b11111, 0, 0, 0));
        run_random(150);
        settle();

        sb.close();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
